/* rtl/akcp_pkg.sv */
// Shared constants for the ASCII key command parser: character codes,
// register indexes, field widths and configuration reset values.
// No dependencies.
`default_nettype none

package akcp_pkg;

    localparam int VALUE_BITS_DEFAULT = 16;

    // Field widths fixed by the command format
    localparam int CHAN_W = 4;
    localparam int DUTY_W = 7;
    localparam int TIME_W = 16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHANNEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 1'b1;
    localparam int CFG_DATA_W = DUTY_W;

    localparam logic [CHAN_W-1:0] MAX_CHANNEL_RESET = 4'd11;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RESET    = 7'd100;

    // Message characters
    localparam logic [7:0] CHAR_PRESS   = 8'h50;
    localparam logic [7:0] CHAR_RELEASE = 8'h52;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    // Shortest legal message, in bytes
    localparam logic [2:0] MIN_MSG_LEN = 3'd5;

endpackage

`default_nettype wire

/* rtl/ascii_key_command_parser.sv */
// ASCII key command parser top level: byte parse state machine and result register.
// Depends on akcp_pkg.
//
// Takes one message byte per item and returns one result item on the byte
// marked end_of_msg, for messages P:ch:duty[:t[:fd[:ft]]] and R:ch:duty.
// Each byte is decoded by the parse state machine, and an item can be accepted
// every cycle while in_ready is high. The single result register hands a
// finished result out in the same cycle that the next byte comes in, so the
// input stalls only while a result is held at the output by a low out_ready.
// A result appears in the cycle after its last byte is accepted. Numbers
// saturate at 2^VALUE_BITS-1. On error (status 1) all other result fields are zero.
// Write max_channel and max_duty only while no message is in progress.
`default_nettype none

module ascii_key_command_parser #(
    parameter int VALUE_BITS = akcp_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_wr_en,
    input  wire logic [akcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [akcp_pkg::CFG_DATA_W-1:0] cfg_data,
    // byte input
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      char_in,
    input  wire logic                            end_of_msg,
    // result output
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 status,
    output logic                                 is_release,
    output logic [akcp_pkg::CHAN_W-1:0]          key_channel,
    output logic [akcp_pkg::DUTY_W-1:0]          strike_duty,
    output logic [akcp_pkg::TIME_W-1:0]          strike_time,
    output logic [akcp_pkg::DUTY_W-1:0]          hold_duty,
    output logic [akcp_pkg::TIME_W-1:0]          hold_time
);

    localparam int CW = akcp_pkg::CHAN_W;
    localparam int DW = akcp_pkg::DUTY_W;
    localparam int TW = akcp_pkg::TIME_W;
    localparam int VB = VALUE_BITS;

    localparam logic [2:0] PH_TYPE   = 3'd0;
    localparam logic [2:0] PH_COLON1 = 3'd1;
    localparam logic [2:0] PH_CHAN   = 3'd2;
    localparam logic [2:0] PH_DUTY   = 3'd3;
    localparam logic [2:0] PH_OPT    = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // configuration registers
    logic [CW-1:0] max_channel_reg;
    logic [DW-1:0] max_duty_reg;

    // message state
    logic [2:0]    phase_reg, phase_next;
    logic [2:0]    byte_count_reg, byte_count_next;
    logic [VB-1:0] accum_reg, accum_next;
    logic          release_reg, release_next;
    logic [CW-1:0] channel_reg, channel_next;
    logic [DW-1:0] duty_reg, duty_next;
    logic [VB-1:0] strike_time_reg, strike_time_next;
    logic [VB-1:0] hold_duty_reg, hold_duty_next;
    logic [VB-1:0] hold_time_reg, hold_time_next;
    logic          failed_reg, failed_next;

    // result register
    logic          res_valid_reg, res_valid_next;
    logic          status_reg;
    logic          is_release_reg;
    logic [CW-1:0] key_channel_reg;
    logic [DW-1:0] strike_duty_reg;
    logic [TW-1:0] strike_time_out_reg;
    logic [DW-1:0] hold_duty_out_reg;
    logic [TW-1:0] hold_time_out_reg;

    logic          in_accept;
    logic          is_digit;
    logic          is_colon;
    logic [VB+3:0] acc_prod;
    logic [VB-1:0] acc_sat;
    logic [VB-1:0] max_chan_ext;
    logic [VB-1:0] max_duty_ext;
    logic [2:0]    bc_inc;

    // state after this byte, before end-of-message handling
    logic [2:0]    t_phase;
    logic [VB-1:0] t_acc;
    logic          t_rel;
    logic [CW-1:0] t_ch;
    logic [DW-1:0] t_duty;
    logic [VB-1:0] t_st;
    logic [VB-1:0] t_hd;
    logic [VB-1:0] t_ht;
    logic          t_fail;

    // end-of-message values
    logic          f_ok;
    logic [DW-1:0] f_duty;
    logic [VB-1:0] f_st;
    logic [VB-1:0] f_hd;
    logic [VB-1:0] f_ht;
    logic [VB+TW-1:0] st_ext;
    logic [VB+TW-1:0] ht_ext;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = !res_valid_reg || out_ready;

    assign is_digit = (char_in >= akcp_pkg::CHAR_ZERO) && (char_in <= akcp_pkg::CHAR_NINE);
    assign is_colon = (char_in == akcp_pkg::CHAR_COLON);

    assign max_chan_ext = {{(VB-CW){1'b0}}, max_channel_reg};
    assign max_duty_ext = {{(VB-DW){1'b0}}, max_duty_reg};

    // accum * 10 + digit, saturated
    assign acc_prod = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                    + {{VB{1'b0}}, char_in[3:0]};
    assign acc_sat  = (acc_prod[VB+3:VB] != 4'b0) ? {VB{1'b1}} : acc_prod[VB-1:0];

    assign bc_inc = (byte_count_reg < akcp_pkg::MIN_MSG_LEN) ? byte_count_reg + 3'd1
                                                             : byte_count_reg;

    // per-byte parse step
    always_comb
    begin
        t_phase = phase_reg;
        t_acc   = accum_reg;
        t_rel   = release_reg;
        t_ch    = channel_reg;
        t_duty  = duty_reg;
        t_st    = strike_time_reg;
        t_hd    = hold_duty_reg;
        t_ht    = hold_time_reg;
        t_fail  = failed_reg;
        if (!failed_reg && phase_reg != PH_DONE)
        begin
            if ((phase_reg == PH_CHAN || phase_reg == PH_DUTY || phase_reg == PH_OPT)
                && is_digit)
            begin
                t_acc = acc_sat;
            end
            else
            begin
                case (phase_reg)
                    PH_TYPE:
                    begin
                        if (char_in == akcp_pkg::CHAR_PRESS)
                        begin
                            t_rel   = 1'b0;
                            t_phase = PH_COLON1;
                        end
                        else if (char_in == akcp_pkg::CHAR_RELEASE)
                        begin
                            t_rel   = 1'b1;
                            t_phase = PH_COLON1;
                        end
                        else
                        begin
                            t_fail = 1'b1;
                        end
                    end
                    PH_COLON1:
                    begin
                        if (is_colon)
                        begin
                            t_phase = PH_CHAN;
                            t_acc   = '0;
                        end
                        else
                        begin
                            t_fail = 1'b1;
                        end
                    end
                    PH_CHAN:
                    begin
                        if (accum_reg > max_chan_ext || !is_colon)
                        begin
                            t_fail = 1'b1;
                        end
                        else
                        begin
                            t_ch    = accum_reg[CW-1:0];
                            t_acc   = '0;
                            t_phase = PH_DUTY;
                        end
                    end
                    PH_DUTY:
                    begin
                        if (accum_reg > max_duty_ext)
                        begin
                            t_fail = 1'b1;
                        end
                        else
                        begin
                            t_duty = accum_reg[DW-1:0];
                            if (!release_reg && is_colon)
                            begin
                                t_acc   = '0;
                                t_phase = PH_OPT;
                            end
                            else
                            begin
                                t_phase = PH_DONE;
                            end
                        end
                    end
                    PH_OPT:
                    begin
                        // fill the first slot still zero
                        if (strike_time_reg == '0)
                            t_st = accum_reg;
                        else if (hold_duty_reg == '0)
                            t_hd = accum_reg;
                        else if (hold_time_reg == '0)
                            t_ht = accum_reg;
                        else
                            t_fail = 1'b1;
                        if (!t_fail)
                        begin
                            if (is_colon)
                                t_acc = '0;
                            else
                                t_phase = PH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // end-of-message decision
    always_comb
    begin
        f_ok   = 1'b1;
        f_duty = t_duty;
        f_st   = t_st;
        f_hd   = t_hd;
        f_ht   = t_ht;
        if (bc_inc < akcp_pkg::MIN_MSG_LEN || t_fail)
        begin
            f_ok = 1'b0;
        end
        else
        begin
            case (t_phase)
                PH_DUTY:
                begin
                    if (t_acc > max_duty_ext)
                        f_ok = 1'b0;
                    else
                        f_duty = t_acc[DW-1:0];
                end
                PH_OPT:
                begin
                    if (t_st == '0)
                        f_st = t_acc;
                    else if (t_hd == '0)
                        f_hd = t_acc;
                    else if (t_ht == '0)
                        f_ht = t_acc;
                    else
                        f_ok = 1'b0;
                end
                PH_DONE:
                begin
                end
                default:
                begin
                    f_ok = 1'b0;
                end
            endcase
            if (f_ok && !t_rel && f_hd > max_duty_ext)
                f_ok = 1'b0;
        end
    end

    assign st_ext = {{TW{1'b0}}, f_st};
    assign ht_ext = {{TW{1'b0}}, f_ht};

    // next message state: clear after the last byte
    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        accum_next       = accum_reg;
        release_next     = release_reg;
        channel_next     = channel_reg;
        duty_next        = duty_reg;
        strike_time_next = strike_time_reg;
        hold_duty_next   = hold_duty_reg;
        hold_time_next   = hold_time_reg;
        failed_next      = failed_reg;
        if (in_accept)
        begin
            if (end_of_msg)
            begin
                phase_next       = PH_TYPE;
                byte_count_next  = 3'd0;
                accum_next       = '0;
                release_next     = 1'b0;
                channel_next     = '0;
                duty_next        = '0;
                strike_time_next = '0;
                hold_duty_next   = '0;
                hold_time_next   = '0;
                failed_next      = 1'b0;
            end
            else
            begin
                phase_next       = t_phase;
                byte_count_next  = bc_inc;
                accum_next       = t_acc;
                release_next     = t_rel;
                channel_next     = t_ch;
                duty_next        = t_duty;
                strike_time_next = t_st;
                hold_duty_next   = t_hd;
                hold_time_next   = t_ht;
                failed_next      = t_fail;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (in_accept && end_of_msg)
            res_valid_next = 1'b1;
        else if (out_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_channel_reg <= akcp_pkg::MAX_CHANNEL_RESET;
            max_duty_reg    <= akcp_pkg::MAX_DUTY_RESET;
            phase_reg       <= PH_TYPE;
            byte_count_reg  <= 3'd0;
            accum_reg       <= '0;
            release_reg     <= 1'b0;
            channel_reg     <= '0;
            duty_reg        <= '0;
            strike_time_reg <= '0;
            hold_duty_reg   <= '0;
            hold_time_reg   <= '0;
            failed_reg      <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    akcp_pkg::REG_MAX_CHANNEL: max_channel_reg <= cfg_data[CW-1:0];
                    akcp_pkg::REG_MAX_DUTY:    max_duty_reg    <= cfg_data[DW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            accum_reg       <= accum_next;
            release_reg     <= release_next;
            channel_reg     <= channel_next;
            duty_reg        <= duty_next;
            strike_time_reg <= strike_time_next;
            hold_duty_reg   <= hold_duty_next;
            hold_time_reg   <= hold_time_next;
            failed_reg      <= failed_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // result payload; zero every other field on error, the strike time and hold fields on release
    always_ff @(posedge clk)
    begin
        if (in_accept && end_of_msg)
        begin
            status_reg          <= !f_ok;
            is_release_reg      <= f_ok && t_rel;
            key_channel_reg     <= f_ok ? t_ch : '0;
            strike_duty_reg     <= f_ok ? f_duty : '0;
            strike_time_out_reg <= (f_ok && !t_rel) ? st_ext[TW-1:0] : '0;
            hold_duty_out_reg   <= (f_ok && !t_rel) ? f_hd[DW-1:0] : '0;
            hold_time_out_reg   <= (f_ok && !t_rel) ? ht_ext[TW-1:0] : '0;
        end
    end

    assign out_valid   = res_valid_reg;
    assign status      = status_reg;
    assign is_release  = is_release_reg;
    assign key_channel = key_channel_reg;
    assign strike_duty = strike_duty_reg;
    assign strike_time = strike_time_out_reg;
    assign hold_duty   = hold_duty_out_reg;
    assign hold_time   = hold_time_out_reg;

`ifndef SYNTHESIS
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !is_release && key_channel == '0 && strike_duty == '0
            && strike_time == '0 && hold_duty == '0 && hold_time == '0)
        else $error("error result carries nonzero fields");

    a_release_no_timing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status && is_release |->
            strike_time == '0 && hold_duty == '0 && hold_time == '0)
        else $error("release result carries press fields");

    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> key_channel <= max_channel_reg
            && strike_duty <= max_duty_reg && hold_duty <= max_duty_reg)
        else $error("accepted result out of configured range");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && end_of_msg |=> phase_reg == PH_TYPE && byte_count_reg == 3'd0
            && !failed_reg && out_valid)
        else $error("message state not cleared after last byte");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= akcp_pkg::MIN_MSG_LEN)
        else $error("byte count past saturation");
`endif

endmodule

`default_nettype wire
